### src/wetp_pkg.sv
`timescale 1ns / 1ps
package wetp_pkg;

  typedef enum logic [3:0] {
    CMD_FRAME_SETUP    = 4'd0,
    CMD_SECTION_END    = 4'd1,
    CMD_RSP_START      = 4'd2,
    CMD_RSP_COMPLETE   = 4'd3,
    CMD_RSP_RESUME     = 4'd4,
    CMD_AUDIO_START    = 4'd5,
    CMD_AUDIO_COMPLETE = 4'd6,
    CMD_FRAME_END      = 4'd7,
    CMD_READ           = 4'd8
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RD,
    ST_WR,
    ST_DIV,
    ST_OUT
  } state_e;

  localparam logic [3:0] CH_FPS   = 4'd0;
  localparam logic [3:0] CH_TOTAL = 4'd1;
  localparam logic [3:0] CH_AUDIO = 4'd2;
  localparam logic [3:0] CH_UNIT0 = 4'd3;
  localparam logic [3:0] CH_TMEM  = 4'd5;
  localparam logic [3:0] CH_CBUSY = 4'd6;
  localparam logic [3:0] CH_PIPE  = 4'd7;

  // Up to five sample updates per item (frame_end).
  localparam int unsigned JOBS = 5;

  typedef struct packed {
    logic       clr;
    logic       latch;
    logic       exec;
    logic       rd;
    logic       wr;
    logic       div;
    logic       out_load;
    logic [2:0] job;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] njobs;
    logic       clear_done;
    logic       out_full;
  } dp_status_t;

endpackage

### src/wetp_in_if.sv
`timescale 1ns / 1ps
interface wetp_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [3:0]  channel;
  logic        unit;
  logic [31:0] timestamp;
  logic [31:0] tmem_busy;
  logic [31:0] command_busy;
  logic [31:0] pipe_busy;

  modport source (output valid, cmd, channel, unit, timestamp, tmem_busy, command_busy,
                  pipe_busy, input ready);
  modport sink (input valid, cmd, channel, unit, timestamp, tmem_busy, command_busy,
                pipe_busy, output ready);
endinterface

### src/wetp_out_if.sv
`timescale 1ns / 1ps
interface wetp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  out_channel;
  logic [31:0] window_total;
  logic [31:0] window_average;

  modport source (output valid, out_channel, window_total, window_average, input ready);
  modport sink (input valid, out_channel, window_total, window_average, output ready);
endinterface

### src/wetp_ram.sv
`timescale 1ns / 1ps
module wetp_ram #(
  parameter int unsigned WIDTH   = 32,
  parameter int unsigned ENTRIES = 512
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(ENTRIES)-1:0] waddr_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic [$clog2(ENTRIES)-1:0] raddr_i,
  output logic [WIDTH-1:0]           rdata_o
);
  logic [WIDTH-1:0] mem_q [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/wetp_ctrl.sv
`timescale 1ns / 1ps
module wetp_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  wetp_pkg::dp_status_t   status_i,
  output wetp_pkg::ctrl_cmd_t    cmd_o
);
  import wetp_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] job_q, job_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      job_q   <= '0;
    end else begin
      state_q <= state_d;
      job_q   <= job_d;
    end
  end

  always_comb begin
    state_d = state_q;
    job_d   = job_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        job_d   = '0;
        state_d = (status_i.njobs == 3'd0) ? ST_DIV : ST_RD;
      end
      ST_RD: state_d = ST_WR;
      ST_WR: begin
        if (job_q == status_i.njobs - 3'd1) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_RD;
          job_d   = job_q + 3'd1;
        end
      end
      ST_DIV: state_d = ST_OUT;
      ST_OUT: if (!status_i.out_full) state_d = ST_IDLE;
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.job  = job_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: cmd_o.clr = 1'b1;
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      ST_EXEC: cmd_o.exec = 1'b1;
      ST_RD:   cmd_o.rd   = 1'b1;
      ST_WR:   cmd_o.wr   = 1'b1;
      ST_DIV:  cmd_o.div  = 1'b1;
      ST_OUT:  cmd_o.out_load = !status_i.out_full;
      default: cmd_o = '0;
    endcase
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_WR |-> job_q < status_i.njobs)
    else $error("sample update index beyond job count");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == ST_EXEC)
    else $error("accepted beat did not start execution");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> !status_i.out_full)
    else $error("result loaded over an untaken result");
endmodule

### src/wetp_dp.sv
`timescale 1ns / 1ps
module wetp_dp #(
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned CHANNELS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  wetp_pkg::ctrl_cmd_t   cmd_i,
  output wetp_pkg::dp_status_t  status_o,
  input  logic [3:0]            cmd_in_i,
  input  logic [3:0]            channel_i,
  input  logic                  unit_i,
  input  logic [31:0]           timestamp_i,
  input  logic [31:0]           tmem_busy_i,
  input  logic [31:0]           command_busy_i,
  input  logic [31:0]           pipe_busy_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [3:0]            out_channel_o,
  output logic [31:0]           window_total_o,
  output logic [31:0]           window_average_o
);
  import wetp_pkg::*;

  localparam int unsigned SLOT_W  = $clog2(DEPTH);
  localparam int unsigned CH_W    = $clog2(CHANNELS);
  localparam int unsigned ENTRIES = CHANNELS * DEPTH;
  localparam int unsigned MEM_AW  = $clog2(ENTRIES);
  // Reciprocal for the divide by DEPTH; the estimate is low by at most one.
  localparam logic [32:0] RECIP_W = 33'((64'd1 << 32) / DEPTH);
  localparam logic [31:0] RECIP   = RECIP_W[31:0];

  // Latched item
  cmd_e        cmd_q;
  logic [3:0]  ch_q;
  logic        unit_q;
  logic [31:0] ts_q, tmem_q, cbusy_q, pbusy_q;

  // Profiler state
  logic [SLOT_W-1:0] frame_slot_q, frame_slot_d;
  logic [SLOT_W-1:0] unit_slot_q [2];
  logic [SLOT_W-1:0] unit_slot_d [2];
  logic [SLOT_W-1:0] audio_slot_q, audio_slot_d;
  logic [31:0]       unit_pend_q [2];
  logic [31:0]       unit_pend_d [2];
  logic [31:0]       last_mark_q, last_mark_d;
  logic [31:0]       frame_begin_q, frame_begin_d;
  logic [31:0]       prior_fb_q, prior_fb_d;
  logic [31:0]       audio_begin_q, audio_begin_d;
  logic [31:0]       preempt_q, preempt_d;
  logic [31:0]       totals_q [CHANNELS];

  // Sample update jobs
  logic [CH_W-1:0]   job_ch_q [JOBS];
  logic [CH_W-1:0]   job_ch_d [JOBS];
  logic [31:0]       job_val_q [JOBS];
  logic [31:0]       job_val_d [JOBS];
  logic [SLOT_W-1:0] slot_q, slot_d;

  logic [MEM_AW-1:0] clr_cnt_q;
  logic [MEM_AW-1:0] addr;
  logic [31:0]       rdata;
  logic [CH_W-1:0]   cur_ch;
  logic [31:0]       cur_val;
  logic              ch_ok;

  logic [31:0] tot;
  logic [31:0] tot_q;
  logic [63:0] prod_q;
  logic [31:0] q_est, rem, avg;
  logic [3:0]  och_q;

  function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
  endfunction

  assign ch_ok   = 32'(ch_q) < CHANNELS;
  assign cur_ch  = job_ch_q[cmd_i.job];
  assign cur_val = job_val_q[cmd_i.job];
  assign addr    = MEM_AW'(cur_ch) * MEM_AW'(DEPTH) + MEM_AW'(slot_q);

  always_comb begin
    status_o            = '0;
    status_o.clear_done = clr_cnt_q == MEM_AW'(ENTRIES - 1);
    status_o.out_full   = out_valid_o && !out_ready_i;
    unique case (cmd_q)
      CMD_SECTION_END:    status_o.njobs = ch_ok ? 3'd1 : 3'd0;
      CMD_RSP_COMPLETE:   status_o.njobs = 3'd1;
      CMD_AUDIO_COMPLETE: status_o.njobs = 3'd1;
      CMD_FRAME_END:      status_o.njobs = 3'(JOBS);
      default:            status_o.njobs = 3'd0;
    endcase
  end

  // State update of one item; sample writes are queued as jobs.
  always_comb begin
    frame_slot_d   = frame_slot_q;
    unit_slot_d    = unit_slot_q;
    audio_slot_d   = audio_slot_q;
    unit_pend_d    = unit_pend_q;
    last_mark_d    = last_mark_q;
    frame_begin_d  = frame_begin_q;
    prior_fb_d     = prior_fb_q;
    audio_begin_d  = audio_begin_q;
    preempt_d      = preempt_q;
    slot_d         = frame_slot_q;
    job_ch_d       = job_ch_q;
    job_val_d      = job_val_q;
    unique case (cmd_q)
      CMD_FRAME_SETUP: begin
        frame_slot_d  = next_slot(frame_slot_q);
        preempt_d     = '0;
        last_mark_d   = ts_q;
        frame_begin_d = ts_q;
      end
      CMD_SECTION_END: begin
        if (ch_ok) begin
          job_ch_d[0]   = CH_W'(ch_q);
          job_val_d[0]  = ts_q - last_mark_q - preempt_q;
          frame_begin_d = frame_begin_q + preempt_q;
          preempt_d     = '0;
          last_mark_d   = ts_q;
        end
      end
      CMD_RSP_START: unit_pend_d[unit_q] = ts_q;
      CMD_RSP_COMPLETE: begin
        job_ch_d[0]          = CH_W'(CH_UNIT0) + CH_W'(unit_q);
        job_val_d[0]         = ts_q - unit_pend_q[unit_q];
        slot_d               = unit_slot_q[unit_q];
        unit_pend_d[unit_q]  = '0;
        unit_slot_d[unit_q]  = next_slot(unit_slot_q[unit_q]);
      end
      CMD_RSP_RESUME: unit_pend_d[0] = ts_q - unit_pend_q[0];
      CMD_AUDIO_START: audio_begin_d = ts_q;
      CMD_AUDIO_COMPLETE: begin
        job_ch_d[0]  = CH_W'(CH_AUDIO);
        job_val_d[0] = ts_q - audio_begin_q;
        preempt_d    = ts_q - audio_begin_q;
        slot_d       = audio_slot_q;
        audio_slot_d = next_slot(audio_slot_q);
      end
      CMD_FRAME_END: begin
        job_ch_d[0]  = CH_W'(CH_FPS);
        job_val_d[0] = frame_begin_q - prior_fb_q;
        job_ch_d[1]  = CH_W'(CH_TOTAL);
        job_val_d[1] = ts_q - (frame_begin_q + preempt_q);
        job_ch_d[2]  = CH_W'(CH_TMEM);
        job_val_d[2] = tmem_q;
        job_ch_d[3]  = CH_W'(CH_CBUSY);
        job_val_d[3] = cbusy_q;
        job_ch_d[4]  = CH_W'(CH_PIPE);
        job_val_d[4] = pbusy_q;
        prior_fb_d   = frame_begin_q;
        last_mark_d  = ts_q;
        preempt_d    = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_slot_q  <= SLOT_W'(DEPTH - 1);
      unit_slot_q   <= '{default: '0};
      audio_slot_q  <= '0;
      unit_pend_q   <= '{default: '0};
      last_mark_q   <= '0;
      frame_begin_q <= '0;
      prior_fb_q    <= '0;
      audio_begin_q <= '0;
      preempt_q     <= '0;
      totals_q      <= '{default: '0};
      clr_cnt_q     <= '0;
      out_valid_o   <= 1'b0;
    end else begin
      if (cmd_i.clr && !status_o.clear_done) begin
        clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
      end
      if (cmd_i.exec) begin
        frame_slot_q  <= frame_slot_d;
        unit_slot_q   <= unit_slot_d;
        audio_slot_q  <= audio_slot_d;
        unit_pend_q   <= unit_pend_d;
        last_mark_q   <= last_mark_d;
        frame_begin_q <= frame_begin_d;
        prior_fb_q    <= prior_fb_d;
        audio_begin_q <= audio_begin_d;
        preempt_q     <= preempt_d;
      end
      if (cmd_i.wr) begin
        totals_q[cur_ch] <= totals_q[cur_ch] - rdata + cur_val;
      end
      if (cmd_i.out_load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q   <= cmd_e'(cmd_in_i);
      ch_q    <= channel_i;
      unit_q  <= unit_i;
      ts_q    <= timestamp_i;
      tmem_q  <= tmem_busy_i;
      cbusy_q <= command_busy_i;
      pbusy_q <= pipe_busy_i;
    end
    if (cmd_i.exec) begin
      slot_q    <= slot_d;
      job_ch_q  <= job_ch_d;
      job_val_q <= job_val_d;
    end
    if (cmd_i.div) begin
      tot_q  <= tot;
      prod_q <= 64'(tot) * 64'(RECIP);
      och_q  <= ch_q;
    end
    if (cmd_i.out_load) begin
      out_channel_o    <= och_q;
      window_total_o   <= tot_q;
      window_average_o <= avg;
    end
  end

  assign tot   = ch_ok ? totals_q[CH_W'(ch_q)] : '0;
  assign q_est = prod_q[63:32];
  assign rem   = tot_q - q_est * 32'(DEPTH);
  assign avg   = (rem >= 32'(DEPTH)) ? q_est + 32'd1 : q_est;

  wetp_ram #(
    .WIDTH   (32),
    .ENTRIES (ENTRIES)
  ) u_samples (
    .clk_i   (clk_i),
    .we_i    (cmd_i.clr || cmd_i.wr),
    .waddr_i (cmd_i.clr ? clr_cnt_q : addr),
    .wdata_i (cmd_i.clr ? 32'd0 : cur_val),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.out_load) |-> out_valid_o)
    else $error("loaded result not presented");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(frame_slot_q) < DEPTH && 32'(audio_slot_q) < DEPTH)
    else $error("slot pointer out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr |-> 32'(addr) < ENTRIES)
    else $error("sample address out of range");
endmodule

### src/windowed_event_time_profiler.sv
`timescale 1ns / 1ps
// Each accepted input beat runs through EXEC, then N sample updates, DIV and OUT; N is the
// number of sample updates (0 for most commands, 1 for in-range section ends and unit/audio
// completions, 5 for frame_end); each update is a read and then a write of the sample RAM.
// A new beat is taken only once the last result is loaded; a result may wait in the output
// register. Reset: asynchronous, active low; afterwards the sample RAM is zeroed in a
// clearing pass over all CHANNELS*DEPTH entries, during which no input beat is accepted.
module windowed_event_time_profiler #(
  parameter int unsigned DEPTH    = 32,
  parameter int unsigned CHANNELS = 16
) (
  input logic       clk_i,
  input logic       rst_ni,
  wetp_in_if.sink   in_i,
  wetp_out_if.source out_o
);
  import wetp_pkg::*;

  ctrl_cmd_t  ctrl_cmd;
  dp_status_t dp_status;

  wetp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (dp_status),
    .cmd_o      (ctrl_cmd)
  );

  wetp_dp #(
    .DEPTH    (DEPTH),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (ctrl_cmd),
    .status_o         (dp_status),
    .cmd_in_i         (in_i.cmd),
    .channel_i        (in_i.channel),
    .unit_i           (in_i.unit),
    .timestamp_i      (in_i.timestamp),
    .tmem_busy_i      (in_i.tmem_busy),
    .command_busy_i   (in_i.command_busy),
    .pipe_busy_i      (in_i.pipe_busy),
    .out_valid_o      (out_o.valid),
    .out_ready_i      (out_o.ready),
    .out_channel_o    (out_o.out_channel),
    .window_total_o   (out_o.window_total),
    .window_average_o (out_o.window_average)
  );
endmodule

### tb/sv/windowed_event_time_profiler_test.sv
`timescale 1ns / 1ps
module windowed_event_time_profiler_test;
  import wetp_pkg::*;

  localparam int unsigned DEPTH = 32;
  localparam int unsigned CHANNELS = 16;
  localparam int unsigned STALL_LIMIT = 20000;

  typedef struct packed {
    logic [3:0]  channel;
    logic [31:0] total;
    logic [31:0] average;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  wetp_in_if  ev_if ();
  wetp_out_if rpt_if ();

  windowed_event_time_profiler #(.DEPTH(DEPTH), .CHANNELS(CHANNELS)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (ev_if),
    .out_o (rpt_if)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Shadow copy of the profiler state.
  logic [31:0] samples [CHANNELS][DEPTH];
  logic [31:0] totals [CHANNELS];
  logic [4:0]  frame_slot;
  logic [4:0]  unit_slot [2];
  logic [4:0]  audio_slot;
  logic [31:0] unit_start [2];
  logic [31:0] last_mark;
  logic [31:0] frame_begin;
  logic [31:0] prev_frame_begin;
  logic [31:0] audio_begin;
  logic [31:0] preempt;

  report_t     pending_reports [$];
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  bit          stall_heavy = 1'b0;

  function automatic logic [4:0] bump_slot(input logic [4:0] s);
    return (s == DEPTH - 1) ? 5'd0 : s + 5'd1;
  endfunction

  function automatic void store_sample(input int unsigned ch, input logic [31:0] v,
                                       input logic [4:0] s);
    if (ch < CHANNELS) begin
      totals[ch] = totals[ch] - samples[ch][s] + v;
      samples[ch][s] = v;
    end
  endfunction

  function automatic void finish_section(input int unsigned ch, input logic [31:0] ts);
    logic [31:0] d;
    d = ts - last_mark;
    if (preempt != 0) begin
      d = d - preempt;
      frame_begin = frame_begin + preempt;
      preempt = 0;
    end
    store_sample(ch, d, frame_slot);
    last_mark = ts;
  endfunction

  function automatic void clear_profile();
    foreach (samples[c, s]) samples[c][s] = 0;
    foreach (totals[c]) totals[c] = 0;
    frame_slot = 5'(DEPTH - 1);
    unit_slot[0] = 0;
    unit_slot[1] = 0;
    audio_slot = 0;
    unit_start[0] = 0;
    unit_start[1] = 0;
    last_mark = 0;
    frame_begin = 0;
    prev_frame_begin = 0;
    audio_begin = 0;
    preempt = 0;
  endfunction

  function automatic report_t profile_event(input logic [3:0] cmd, input logic [3:0] ch,
                                            input logic unit, input logic [31:0] ts,
                                            input logic [31:0] tmem, input logic [31:0] cbusy,
                                            input logic [31:0] pbusy);
    report_t r;
    logic [31:0] t;
    case (cmd)
      CMD_FRAME_SETUP: begin
        frame_slot = bump_slot(frame_slot);
        preempt = 0;
        last_mark = ts;
        frame_begin = ts;
      end
      CMD_SECTION_END: begin
        if (ch < CHANNELS) finish_section(ch, ts);
      end
      CMD_RSP_START: unit_start[unit] = ts;
      CMD_RSP_COMPLETE: begin
        store_sample(CH_UNIT0 + unit, ts - unit_start[unit], unit_slot[unit]);
        unit_start[unit] = 0;
        unit_slot[unit] = bump_slot(unit_slot[unit]);
      end
      CMD_RSP_RESUME: unit_start[0] = ts - unit_start[0];
      CMD_AUDIO_START: audio_begin = ts;
      CMD_AUDIO_COMPLETE: begin
        t = ts - audio_begin;
        preempt = t;
        store_sample(CH_AUDIO, t, audio_slot);
        audio_slot = bump_slot(audio_slot);
      end
      CMD_FRAME_END: begin
        store_sample(CH_FPS, frame_begin - prev_frame_begin, frame_slot);
        prev_frame_begin = frame_begin;
        last_mark = frame_begin + preempt;
        preempt = 0;
        finish_section(CH_TOTAL, ts);
        store_sample(CH_TMEM, tmem, frame_slot);
        store_sample(CH_CBUSY, cbusy, frame_slot);
        store_sample(CH_PIPE, pbusy, frame_slot);
      end
      default: ;
    endcase
    r.channel = ch;
    r.total = (ch < CHANNELS) ? totals[ch] : 32'd0;
    r.average = r.total / DEPTH;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(3, 1);
    return $urandom_range(30, 4);
  endfunction

  initial begin
    ev_if.valid = 1'b0;
    ev_if.cmd = CMD_READ;
    ev_if.channel = '0;
    ev_if.unit = 1'b0;
    ev_if.timestamp = '0;
    ev_if.tmem_busy = '0;
    ev_if.command_busy = '0;
    ev_if.pipe_busy = '0;
    rpt_if.ready = 1'b0;
  end

  // Valid stays high after a beat unless a gap follows, so that a beat sent right away
  // does not deassert and reassert valid at the same falling edge.
  task automatic send_event(input logic [3:0] cmd, input logic [3:0] ch, input logic unit,
                            input logic [31:0] ts, input logic [31:0] tmem = 0,
                            input logic [31:0] cbusy = 0, input logic [31:0] pbusy = 0);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      ev_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    ev_if.valid <= 1'b1;
    ev_if.cmd <= cmd;
    ev_if.channel <= ch;
    ev_if.unit <= unit;
    ev_if.timestamp <= ts;
    ev_if.tmem_busy <= tmem;
    ev_if.command_busy <= cbusy;
    ev_if.pipe_busy <= pbusy;
    do @(posedge clk_i); while (!ev_if.ready);
    pending_reports.push_back(profile_event(cmd, ch, unit, ts, tmem, cbusy, pbusy));
    @(negedge clk_i);
  endtask

  // Result side: ready toggles at the falling edge, beats are checked at the rising edge.
  initial begin
    int unsigned hold;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        rpt_if.ready <= 1'b0;
        hold--;
      end else begin
        rpt_if.ready <= 1'b1;
        if ($urandom_range(99) < (stall_heavy ? 40 : 15)) hold = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rpt_if.valid && rpt_if.ready) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result beat channel %0d total %h", $time,
                 rpt_if.out_channel, rpt_if.window_total);
        errors++;
      end else begin
        report_t w;
        w = pending_reports.pop_front();
        if (rpt_if.out_channel !== w.channel) begin
          $display("%0t: out_channel expected %0d actual %0d", $time, w.channel,
                   rpt_if.out_channel);
          errors++;
        end
        if (rpt_if.window_total !== w.total) begin
          $display("%0t: window_total ch %0d expected %h actual %h", $time, w.channel,
                   w.total, rpt_if.window_total);
          errors++;
        end
        if (rpt_if.window_average !== w.average) begin
          $display("%0t: window_average ch %0d expected %h actual %h", $time, w.channel,
                   w.average, rpt_if.window_average);
          errors++;
        end
      end
    end
  end

  // Watchdog: the clearing pass after reset is covered by the limit.
  always @(posedge clk_i) begin
    if ((ev_if.valid && ev_if.ready) || (rpt_if.valid && rpt_if.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("windowed_event_time_profiler test failed");
      $finish;
    end else
      idle_cycles <= idle_cycles + 1;
  end

  task automatic test_extremes();
    send_event(CMD_READ, 4'd15, 1'b0, 32'h0);
    send_event(CMD_SECTION_END, 4'd9, 1'b0, 32'hFFFF_FFFF);
    send_event(CMD_FRAME_END, 4'd5, 1'b1, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_event(CMD_FRAME_END, 4'd7, 1'b0, 32'hFFFF_FFFF, 32'h8000_0001, 32'h0, 32'h5555_AAAA);
    send_event(CMD_READ, 4'd1, 1'b0, 32'h0);
    send_event(4'd9, 4'd6, 1'b1, 32'hFFFF_FFFF);
    send_event(4'd15, 4'd0, 1'b1, 32'h1234_5678);
  endtask

  task automatic test_each_command();
    send_event(CMD_FRAME_SETUP, 4'd0, 1'b0, 32'd1000);
    send_event(CMD_RSP_START, 4'd3, 1'b0, 32'd1100);
    send_event(CMD_RSP_RESUME, 4'd3, 1'b1, 32'd1300);
    send_event(CMD_RSP_COMPLETE, 4'd3, 1'b0, 32'd1500);
    send_event(CMD_RSP_START, 4'd4, 1'b1, 32'd1600);
    send_event(CMD_RSP_COMPLETE, 4'd4, 1'b1, 32'd1900);
    send_event(CMD_SECTION_END, 4'd8, 1'b0, 32'd2000);
    send_event(CMD_AUDIO_START, 4'd2, 1'b0, 32'd2100);
    send_event(CMD_AUDIO_COMPLETE, 4'd2, 1'b0, 32'd2400);
    send_event(CMD_SECTION_END, 4'd12, 1'b0, 32'd3000);
    send_event(CMD_AUDIO_START, 4'd2, 1'b0, 32'd3100);
    send_event(CMD_AUDIO_COMPLETE, 4'd2, 1'b0, 32'd3150);
    send_event(CMD_FRAME_END, 4'd0, 1'b0, 32'd4000, 32'd10, 32'd20, 32'd30);
    send_event(CMD_READ, 4'd2, 1'b0, 32'd0);
  endtask

  task automatic send_frame();
    logic [31:0] ts;
    int unsigned n;
    ts = $urandom();
    send_event(CMD_FRAME_SETUP, 4'($urandom_range(15)), 1'($urandom_range(1)), ts);
    n = $urandom_range(8, 1);
    repeat (n) begin
      ts = ts + $urandom_range(5000);
      case ($urandom_range(5))
        0: send_event(CMD_RSP_START, 4'(3 + $urandom_range(1)), 1'($urandom_range(1)), ts);
        1: send_event(CMD_RSP_COMPLETE, 4'($urandom_range(15)), 1'($urandom_range(1)), ts);
        2: send_event(CMD_RSP_RESUME, 4'($urandom_range(15)), 1'($urandom_range(1)), ts);
        3: begin
          send_event(CMD_AUDIO_START, 4'd2, 1'($urandom_range(1)), ts);
          ts = ts + $urandom_range(800);
          send_event(CMD_AUDIO_COMPLETE, 4'($urandom_range(15)), 1'($urandom_range(1)), ts);
        end
        default: send_event(CMD_SECTION_END, 4'($urandom_range(15, 8)),
                            1'($urandom_range(1)), ts);
      endcase
    end
    ts = ts + $urandom_range(3000);
    send_event(CMD_FRAME_END, 4'($urandom_range(15)), 1'($urandom_range(1)), ts,
               $urandom(), $urandom(), $urandom());
  endtask

  task automatic test_random_traffic();
    int unsigned sent;
    sent = 0;
    while (sent < 1250) begin
      stall_heavy = ($urandom_range(3) == 0);
      if ($urandom_range(9) < 8) begin
        send_frame();
        sent += 8;
      end else begin
        send_event(4'($urandom_range(15)), 4'($urandom_range(15)), 1'($urandom_range(1)),
                   $urandom(), $urandom(), $urandom(), $urandom());
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned drain;
    clear_profile();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_each_command();
    test_random_traffic();
    ev_if.valid <= 1'b0;
    drain = 0;
    while (pending_reports.size() != 0 && drain < 200000) begin
      @(posedge clk_i);
      drain++;
    end
    repeat (40) @(posedge clk_i);
    if (errors == 0 && pending_reports.size() == 0)
      $display("windowed_event_time_profiler test passed");
    else
      $display("windowed_event_time_profiler test failed");
    $finish;
  end

endmodule

### files.f
src/wetp_pkg.sv
src/wetp_in_if.sv
src/wetp_out_if.sv
src/wetp_ram.sv
src/wetp_ctrl.sv
src/wetp_dp.sv
src/windowed_event_time_profiler.sv
tb/sv/windowed_event_time_profiler_test.sv
